// File: hw/rtl/lspl_pkg.sv
// shared types, constants and codes of the looping sample player
`timescale 1ns / 1ps

package lspl_pkg;

    // default sample memory depth, in words
    localparam int DEFAULT_SAMPLE_DEPTH = 16384;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_ENABLE   = 2'd1;

    // item operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // reciprocal for trunc(2m/3): (m * RECIP3) >> DIV3_SHIFT, exact for 16-bit m
    localparam logic [16:0] RECIP3     = 17'd87382;
    localparam int          DIV3_SHIFT = 17;

    // reciprocal for trunc(n/5): (n * RECIP5) >> DIV5_SHIFT, exact for 20-bit n
    localparam logic [19:0] RECIP5     = 20'd838861;
    localparam int          DIV5_SHIFT = 22;

    typedef struct packed {
        logic [1:0]          operation;
        logic [13:0]         load_address;
        logic signed [15:0]  load_value;
    } in_item_t;

    typedef struct packed {
        logic signed [18:0]  audio_out;
        logic                playing;
    } out_item_t;

    // sample leaving the memory stage
    typedef struct packed {
        logic signed [15:0]  sample;
        logic                playing;
    } src_item_t;

    // filter level leaving the filter stage
    typedef struct packed {
        logic signed [15:0]  level;
        logic                playing;
    } lvl_item_t;

endpackage

// File: hw/rtl/looping_sample_player_lowpass.sv
// top level of the looping sample player with one-pole low-pass output
`timescale 1ns / 1ps

// looping sample player. write transfers (operation 1) store a signed 16-bit word
// in the sample memory, start transfers (operation 2) rewind to position zero and
// enable playback when sample_length is nonzero, and tick transfers (operation 0)
// play the word at the current position (zero when stopped), advance, wrap or stop
// at the end per loop_enable, run the low-pass level += trunc(2*(s-level)/3) and
// return trunc(54*level/10) with the playing flag. only ticks return a result.
// one transfer is taken every cycle unless the result channel stalls; a tick's
// result passes through four register stages (memory read register loaded at the
// transfer edge, filter level register, gain stage, output register). the filter
// level loop closes combinationally through a reciprocal multiply by 2/3. the
// sample memory has no reset: play only words that were
// written. configuration is written through cfg_we / cfg_index / cfg_wdata while
// the block is idle; index 0 is sample_length, index 1 is loop_enable.

module looping_sample_player_lowpass import lspl_pkg::*; #(
    parameter int SAMPLE_DEPTH = DEFAULT_SAMPLE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // item channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data
);

    // memory stage to filter stage
    logic      src_valid;
    logic      src_ready;
    src_item_t src_data;

    // filter stage to gain stage
    logic      lvl_valid;
    logic      lvl_ready;
    lvl_item_t lvl_data;

    // position control, registers and sample memory
    lspl_source #(
        .SAMPLE_DEPTH(SAMPLE_DEPTH)
    ) u_source (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data)
    );

    // low-pass level update, one tick per cycle unless the gain stage stalls
    lspl_filter u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .lvl_data  (lvl_data)
    );

    // output gain and result register
    lspl_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .lvl_data  (lvl_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hw/rtl/lspl_source.sv
// configuration registers, play position control and sample memory
`timescale 1ns / 1ps

module lspl_source import lspl_pkg::*; #(
    parameter int SAMPLE_DEPTH = DEFAULT_SAMPLE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   src_valid,
    input  logic                   src_ready,
    output src_item_t              src_data
);

    localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
    localparam int LEN_W  = (ADDR_W + 1 > CFG_DATA_W) ? ADDR_W + 1 : CFG_DATA_W;
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(SAMPLE_DEPTH);

    logic [CFG_DATA_W-1:0] sample_length_reg;
    logic                  loop_enable_reg;
    logic [ADDR_W-1:0]     pos_reg, pos_next;
    logic                  enabled_reg, enabled_next;

    logic signed [15:0]    mem [SAMPLE_DEPTH];
    logic signed [15:0]    rdata_reg;

    logic                  src_valid_reg;
    logic                  src_on_reg;
    logic                  src_playing_reg;

    logic                  accept;
    logic                  is_tick;
    logic                  is_write;
    logic                  addr_ok;
    logic [LEN_W-1:0]      len_ext;
    logic [LEN_W-1:0]      eff_len;
    logic [ADDR_W:0]       pos_inc;
    logic                  at_end;

    assign s_ready  = !src_valid_reg || src_ready;
    assign accept   = s_valid && s_ready;
    assign is_tick  = (s_data.operation == OP_TICK);
    assign is_write = (s_data.operation == OP_WRITE);
    assign addr_ok  = (32'(s_data.load_address) < 32'(SAMPLE_DEPTH));

    // length saturates at the memory depth
    assign len_ext = LEN_W'(sample_length_reg);
    assign eff_len = (len_ext > DEPTH_LEN) ? DEPTH_LEN : len_ext;
    assign pos_inc = {1'b0, pos_reg} + (ADDR_W + 1)'(1);
    assign at_end  = (LEN_W'(pos_inc) >= eff_len);

    always_comb begin
        pos_next     = pos_reg;
        enabled_next = enabled_reg;
        if (accept) begin
            case (s_data.operation)
                OP_START: begin
                    if (eff_len != '0) begin
                        enabled_next = 1'b1;
                        pos_next     = '0;
                    end else begin
                        enabled_next = 1'b0;
                    end
                end
                OP_TICK: begin
                    if (enabled_reg) begin
                        if (at_end) begin
                            if (loop_enable_reg) begin
                                pos_next = '0;
                            end else begin
                                enabled_next = 1'b0;
                            end
                        end else begin
                            pos_next = pos_inc[ADDR_W-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_length_reg <= '0;
            loop_enable_reg   <= 1'b0;
            pos_reg           <= '0;
            enabled_reg       <= 1'b0;
            src_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_SAMPLE_LENGTH: sample_length_reg <= cfg_wdata;
                    REG_LOOP_ENABLE:   loop_enable_reg   <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            pos_reg     <= pos_next;
            enabled_reg <= enabled_next;
            if (s_ready) begin
                src_valid_reg <= accept && is_tick;
            end
        end
    end

    // stage payload, loaded with each tick
    always_ff @(posedge aclk) begin
        if (accept && is_tick) begin
            src_on_reg      <= enabled_reg;
            src_playing_reg <= enabled_next;
        end
    end

    // sample memory: an accepted in-range write stores a word, an accepted tick does one registered read
    always_ff @(posedge aclk) begin
        if (accept && is_write && addr_ok) begin
            mem[ADDR_W'(s_data.load_address)] <= s_data.load_value;
        end
        if (accept && is_tick) begin
            rdata_reg <= mem[pos_reg];
        end
    end

    assign src_valid        = src_valid_reg;
    assign src_data.sample  = src_on_reg ? rdata_reg : 16'sd0;
    assign src_data.playing = src_playing_reg;

endmodule

// File: hw/rtl/lspl_filter.sv
// one-pole low-pass stage: level += trunc(2*(s-level)/3)
`timescale 1ns / 1ps

module lspl_filter import lspl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      src_valid,
    output logic      src_ready,
    input  src_item_t src_data,
    output logic      lvl_valid,
    input  logic      lvl_ready,
    output lvl_item_t lvl_data
);

    logic signed [15:0] level_reg, level_next;
    logic               lvl_valid_reg;
    logic               lvl_playing_reg;

    logic signed [16:0] diff;
    logic               diff_neg;
    logic [16:0]        diff_abs;
    logic [32:0]        prod;
    logic [15:0]        quot;
    logic signed [16:0] step;
    logic signed [16:0] sum;
    logic               fire;

    assign src_ready = !lvl_valid_reg || lvl_ready;
    assign fire      = src_valid && src_ready;

    always_comb begin
        diff     = $signed({src_data.sample[15], src_data.sample})
                 - $signed({level_reg[15], level_reg});
        diff_neg = diff[16];
        diff_abs = diff_neg ? 17'(-diff) : 17'(diff);
        // trunc(2|d|/3) by reciprocal, |d| fits 16 bits
        prod     = 33'(diff_abs[15:0]) * 33'(RECIP3);
        quot     = prod[DIV3_SHIFT +: 16];
        step     = diff_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        sum      = $signed({level_reg[15], level_reg}) + step;
        level_next = sum[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= '0;
            lvl_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                level_reg <= level_next;
            end
            if (src_ready) begin
                lvl_valid_reg <= src_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            lvl_playing_reg <= src_data.playing;
        end
    end

    assign lvl_valid        = lvl_valid_reg;
    assign lvl_data.level   = level_reg;
    assign lvl_data.playing = lvl_playing_reg;

endmodule

// File: hw/rtl/lspl_scale.sv
// output gain trunc(54*level/10) in two stages, with the output register
`timescale 1ns / 1ps

module lspl_scale import lspl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      lvl_valid,
    output logic      lvl_ready,
    input  lvl_item_t lvl_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic        mul_valid_reg;
    logic [19:0] mag27_reg;
    logic        neg_reg;
    logic        mul_playing_reg;

    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic        out_free;
    logic [15:0] level_abs;
    logic [19:0] abs_ext;
    logic [19:0] mag27;
    logic [39:0] prod;
    logic [17:0] quot;
    logic [18:0] audio;

    assign out_free  = !m_valid_reg || m_ready;
    assign lvl_ready = !mul_valid_reg || out_free;

    // 54/10 = 27/5, 27x by shift and add
    always_comb begin
        level_abs = lvl_data.level[15] ? 16'(~lvl_data.level + 16'sd1)
                                       : 16'(lvl_data.level);
        abs_ext   = 20'(level_abs);
        mag27     = (abs_ext << 4) + (abs_ext << 3) + (abs_ext << 1) + abs_ext;
    end

    always_comb begin
        prod  = 40'(mag27_reg) * 40'(RECIP5);
        quot  = prod[DIV5_SHIFT +: 18];
        audio = neg_reg ? 19'(-{1'b0, quot}) : {1'b0, quot};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (lvl_ready) begin
                mul_valid_reg <= lvl_valid;
            end
            if (out_free) begin
                m_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (lvl_valid && lvl_ready) begin
            mag27_reg       <= mag27;
            neg_reg         <= lvl_data.level[15];
            mul_playing_reg <= lvl_data.playing;
        end
        if (mul_valid_reg && out_free) begin
            m_data_reg.audio_out <= $signed(audio);
            m_data_reg.playing   <= mul_playing_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: tb/lspl_audio_check.sv
// monitor, predictor and result comparison for the looping sample player
`timescale 1ns / 1ps

module lspl_audio_check import lspl_pkg::*; #(
    parameter int DEPTH = DEFAULT_SAMPLE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_item_t              m_data,
    output int                     mismatches,
    output int                     outstanding
);

    logic signed [15:0] sample_mem [DEPTH];
    logic [13:0]        play_pos;
    logic               play_on;
    logic signed [15:0] level;
    logic [14:0]        len_reg;
    logic               loop_reg;
    out_item_t          expected_audio [$];

    task automatic report_mismatch(string what);
        $display("%0t: audio check: %s", $time, what);
        mismatches++;
    endtask

    // one tick: fetch, advance, wrap or stop, filter, gain
    task automatic tick_audio(output out_item_t res);
        int eff;
        int smp;
        int lv;
        int gain;
        smp = 0;
        if (play_on) begin
            eff = (int'(len_reg) > DEPTH) ? DEPTH : int'(len_reg);
            smp = sample_mem[play_pos];
            if (int'(play_pos) + 1 >= eff) begin
                if (loop_reg)
                    play_pos = '0;
                else
                    play_on = 1'b0;
            end else begin
                play_pos = play_pos + 14'd1;
            end
        end
        lv = level;
        lv = lv + (2 * (smp - lv)) / 3;
        level = lv[15:0];
        gain = (54 * lv) / 10;
        res.audio_out = gain[18:0];
        res.playing = play_on;
    endtask

    always @(posedge aclk) begin : watch
        out_item_t res;
        out_item_t want;
        if (!aresetn) begin
            play_pos = '0;
            play_on  = 1'b0;
            level    = '0;
            len_reg  = '0;
            loop_reg = 1'b0;
            expected_audio.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_audio.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = expected_audio.pop_front();
                    if (m_data.audio_out !== want.audio_out)
                        report_mismatch($sformatf("audio_out %0d, expected %0d",
                                                  m_data.audio_out, want.audio_out));
                    if (m_data.playing !== want.playing)
                        report_mismatch($sformatf("playing %0b, expected %0b",
                                                  m_data.playing, want.playing));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_SAMPLE_LENGTH: len_reg = cfg_wdata;
                    REG_LOOP_ENABLE:   loop_reg = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_data.operation)
                    OP_WRITE: sample_mem[s_data.load_address] = s_data.load_value;
                    OP_START: begin
                        if (len_reg != '0) begin
                            play_on  = 1'b1;
                            play_pos = '0;
                        end else begin
                            play_on = 1'b0;
                        end
                    end
                    OP_TICK: begin
                        tick_audio(res);
                        expected_audio.push_back(res);
                    end
                    default: ;
                endcase
            end
        end
        outstanding <= expected_audio.size();
    end

endmodule

// File: tb/tb.sv
// stimulus, handshake pacing and verdict for the looping sample player testbench
`timescale 1ns / 1ps

module tb;
    import lspl_pkg::*;

    localparam int DEPTH = DEFAULT_SAMPLE_DEPTH;
    // operation code the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // register index outside the map, writes must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    // settle time after each drain, padded
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_CYCLES     = 200;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int NUM_PHASES      = 10;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;

    int mismatch_count;
    int pending_results;

    // idle percentages of each side, changed per phase
    int tx_idle_pct = 31;
    int rx_idle_pct = 72;
    // one-cycle request for a long receiver hold-off
    logic rx_hold_start = 1'b0;
    int   rx_hold_left  = 0;

    // stimulus-side view of play state, used only to keep playback on written words
    bit written_word [DEPTH];
    int t_len  = 0;
    bit t_loop = 1'b0;
    int t_pos  = 0;
    bit t_on   = 1'b0;

    // settings walked by the random phases: zero, one, saturating and
    // beyond-depth lengths with both loop modes
    int phase_len  [NUM_PHASES] = '{5, 16, 1, 64, 16384, 0, 33, 32767, 2, 100};
    bit phase_loop [NUM_PHASES] = '{1, 0, 1, 1, 0, 1, 0, 1, 0, 1};

    always #4 aclk = ~aclk;

    looping_sample_player_lowpass #(
        .SAMPLE_DEPTH(DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    lspl_audio_check #(
        .DEPTH(DEPTH)
    ) u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatch_count),
        .outstanding (pending_results)
    );

    // receiver: random stalls, or a long hold-off counted here once requested
    always @(posedge aclk) begin
        if (rx_hold_left != 0) begin
            m_ready      <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_start) begin
            m_ready      <= 1'b0;
            rx_hold_left <= HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic in_item_t mk(logic [1:0] op, logic [13:0] addr,
                                    logic signed [15:0] val);
        in_item_t it;
        it.operation    = op;
        it.load_address = addr;
        it.load_value   = val;
        return it;
    endfunction

    // one transfer on the item channel; valid stays up after the transfer
    // unless the next call idles, so back-to-back items keep valid high
    task automatic send(in_item_t it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // follow play position so ticks never fetch a word that was never written
    task automatic note_item(in_item_t it);
        int eff;
        eff = (t_len > DEPTH) ? DEPTH : t_len;
        case (it.operation)
            OP_WRITE: written_word[it.load_address] = 1'b1;
            OP_START: begin
                t_on = (eff > 0);
                if (eff > 0)
                    t_pos = 0;
            end
            OP_TICK: begin
                if (t_on) begin
                    if (t_pos + 1 >= eff) begin
                        if (t_loop)
                            t_pos = 0;
                        else
                            t_on = 1'b0;
                    end else begin
                        t_pos++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // send an item, first filling the word a playing tick is about to fetch
    task automatic issue(in_item_t it);
        in_item_t fill;
        if (it.operation == OP_TICK && t_on && !written_word[t_pos]) begin
            fill = mk(OP_WRITE, 14'(t_pos), 16'($urandom));
            send(fill);
            note_item(fill);
        end
        send(it);
        note_item(it);
    endtask

    // stop offering and wait until every expected result has come back,
    // then let trailing write/start transfers clear the pipeline
    task automatic drain(int extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // register writes on consecutive cycles; only done with the block idle
    task automatic set_regs(int len, bit loop_on, bit spare);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SAMPLE_LENGTH;
        cfg_wdata <= CFG_DATA_W'(len);
        @(posedge aclk);
        cfg_index <= REG_LOOP_ENABLE;
        // upper bits are junk, only bit 0 counts
        cfg_wdata <= CFG_DATA_W'(($urandom & 32'h7FFE) | 32'(loop_on));
        @(posedge aclk);
        if (spare) begin
            cfg_index <= REG_SPARE;
            cfg_wdata <= CFG_DATA_W'($urandom);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        t_len  = len;
        t_loop = loop_on;
    endtask

    // random item: mostly ticks and writes near the start of memory so
    // playback runs over written words, with starts and ignored codes mixed in
    function automatic in_item_t rand_item();
        in_item_t it;
        int pick;
        it   = in_item_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 58)
            it.operation = OP_TICK;
        else if (pick < 86)
            it.operation = OP_WRITE;
        else if (pick < 95)
            it.operation = OP_START;
        else
            it.operation = OP_UNUSED;
        if (it.operation == OP_WRITE) begin
            if ($urandom_range(0, 99) < 70)
                it.load_address = 14'($urandom_range(0, 127));
            if ($urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 3))
                    0: it.load_value = 16'sh7FFF;
                    1: it.load_value = 16'sh8000;
                    2: it.load_value = 16'sh0000;
                    default: it.load_value = 16'shFFFF;
                endcase
            end
        end
        return it;
    endfunction

    initial begin
        int p;
        int n;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, registers at reset: idle tick, zero-length start, ignored code, writes
        issue(mk(OP_TICK, 14'h3FFF, 16'shFFFF));
        issue(mk(OP_START, 14'h0000, 16'sh0000));
        issue(mk(OP_UNUSED, 14'h2AAA, 16'sh5555));
        issue(mk(OP_WRITE, 14'h3FFF, 16'sh8000));
        issue(mk(OP_WRITE, 14'h0000, 16'sh7FFF));
        issue(mk(OP_WRITE, 14'h0001, 16'sh8000));
        issue(mk(OP_WRITE, 14'h0002, 16'shFFFF));

        // three-word one-shot: stops after the last word, then an idle tick and a restart
        drain(SETTLE_CYCLES);
        set_regs(3, 1'b0, 1'b1);
        issue(mk(OP_START, 14'h3FFF, 16'sh7FFF));
        repeat (4) issue(mk(OP_TICK, 14'h1555, 16'sh8000));
        issue(mk(OP_START, 14'h0000, 16'sh0000));
        issue(mk(OP_TICK, 14'h0000, 16'sh0000));

        // length lowered under a running playback: ends at the next tick
        drain(SETTLE_CYCLES);
        set_regs(1, 1'b0, 1'b0);
        issue(mk(OP_TICK, 14'h0000, 16'sh0000));

        // one-word loop at full scale, then swung to the negative extreme
        drain(SETTLE_CYCLES);
        set_regs(1, 1'b1, 1'b0);
        issue(mk(OP_START, 14'h0000, 16'sh0000));
        repeat (5) issue(mk(OP_TICK, 14'h0000, 16'sh0000));
        issue(mk(OP_WRITE, 14'h0000, 16'sh8000));
        repeat (5) issue(mk(OP_TICK, 14'h0000, 16'sh0000));

        // random phases, one register setting each
        for (p = 0; p < NUM_PHASES; p++) begin
            if (p == 4) begin
                tx_idle_pct = 72;
                rx_idle_pct = 31;
            end
            if (p == 7) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            drain(SETTLE_CYCLES);
            set_regs(phase_len[p], phase_loop[p], p[0]);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold-off while items keep coming: the
                // pipeline fills and the block must stall its input
                if (p == 2 && n == 40) begin
                    s_valid       <= 1'b0;
                    rx_hold_start <= 1'b1;
                    @(posedge aclk);
                    rx_hold_start <= 1'b0;
                end
                // sender pause until every result is back
                if (p == 5 && n == 60)
                    drain(0);
                issue(rand_item());
            end
        end

        drain(SETTLE_CYCLES);
        if (mismatch_count == 0 && pending_results == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: looping_sample_player_lowpass.f
hw/rtl/lspl_pkg.sv
hw/rtl/lspl_source.sv
hw/rtl/lspl_filter.sv
hw/rtl/lspl_scale.sv
hw/rtl/looping_sample_player_lowpass.sv
tb/lspl_audio_check.sv
tb/tb.sv
